@@ rtl/thc_pkg.sv @@
// shared types and constants for the thermostat hysteresis controller
package thc_pkg;

    typedef enum logic [1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_UP     = 2'd1,
        FUNC_DOWN   = 2'd2,
        FUNC_TICK   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        MODE_STOP = 2'd0,
        MODE_HEAT = 2'd1,
        MODE_COOL = 2'd2
    } t_mode;

    localparam logic [1:0] KIND_MEASURED = 2'd0;
    localparam logic [1:0] KIND_SETPOINT = 2'd1;
    localparam logic [1:0] KIND_FAULT    = 2'd2;

    localparam logic [2:0] REG_MARGIN = 3'd0;
    localparam logic [2:0] REG_SP_MAX = 3'd1;
    localparam logic [2:0] REG_SP_MIN = 3'd2;
    localparam logic [2:0] REG_HOLD   = 3'd3;
    localparam logic [2:0] REG_SP_START = 3'd4;

    localparam logic [3:0] MARGIN_RST = 4'd1;
    localparam logic [7:0] HOLD_RST   = 8'd5;
    localparam int         SP_MAX_RST = 30;
    localparam int         SP_MIN_RST = 5;
    localparam int         SP_START_RST = 19;

endpackage

@@ rtl/thermostat_hysteresis_controller.sv @@
// thermostat with hysteresis, button setpoint and display hold
// the result of an accepted word is registered in the output register, or in the skid entry while that one is held
// throughput: one word per cycle while o_stall is low; state and relay decision update in a single pass
// a two-entry output buffer keeps input accepts going while one result waits
// reset (synchronous, active low) clears state and loads the register defaults
module thermostat_hysteresis_controller #(
    parameter int TEMP_BITS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_func,
    input  logic signed [TEMP_BITS-1:0] i_sample_value,
    input  logic                        i_sample_valid,
    input  logic                        i_button_level,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_heat_on,
    output logic                        o_cool_on,
    output logic signed [TEMP_BITS-1:0] o_display_value,
    output logic [1:0]                  o_display_kind,
    output logic                        o_fault,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [4:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int W  = TEMP_BITS;
    localparam int RW = W + 5;

    logic [3:0]          r_margin;
    logic signed [W-1:0] r_sp_max;
    logic signed [W-1:0] r_sp_min;
    logic [7:0]          r_hold_cfg;
    logic signed [W-1:0] r_sp_start;

    logic signed [W-1:0] r_setpoint;
    thc_pkg::t_mode      r_mode;
    logic signed [W-1:0] r_meas;
    logic                r_have;
    logic [7:0]          r_hold;
    logic                r_fault;

    logic signed [W-1:0] n_setpoint;
    thc_pkg::t_mode      n_mode;
    logic signed [W-1:0] n_meas;
    logic                n_have;
    logic [7:0]          n_hold;
    logic                n_fault;

    logic [RW-1:0] r_out;
    logic [RW-1:0] r_skd;
    logic          r_ov;
    logic          r_sv;
    logic [RW-1:0] w_res;

    logic w_acc;
    logic w_take;
    logic w_wr;
    logic [2:0] w_idx;

    logic signed [W+1:0] w_samp_x;
    logic signed [W+1:0] w_sp_x;
    logic signed [W+1:0] w_marg_x;
    logic signed [W:0]   w_cand;
    logic                w_cand_ok;
    logic signed [W-1:0] w_disp;
    logic [1:0]          w_kind;

    assign pready  = 1'b1;
    assign w_idx   = paddr[4:2];
    assign w_wr    = psel && penable && pwrite && pready;
    assign o_stall = r_sv;
    assign w_acc   = i_valid && !r_sv;
    assign w_take  = r_ov && !i_stall;

    always_comb begin
        unique case (w_idx)
            thc_pkg::REG_MARGIN:   prdata = {28'd0, r_margin};
            thc_pkg::REG_SP_MAX:   prdata = 32'(r_sp_max);
            thc_pkg::REG_SP_MIN:   prdata = 32'(r_sp_min);
            thc_pkg::REG_HOLD:     prdata = {24'd0, r_hold_cfg};
            thc_pkg::REG_SP_START: prdata = 32'(r_sp_start);
            default:               prdata = 32'd0;
        endcase
    end

    assign w_samp_x = (W+2)'(i_sample_value);
    assign w_sp_x   = (W+2)'(r_setpoint);
    assign w_marg_x = (W+2)'(signed'({1'b0, r_margin}));
    assign w_cand   = (i_func == thc_pkg::FUNC_UP) ? (W+1)'(r_setpoint) + (W+1)'(1)
                                                   : (W+1)'(r_setpoint) - (W+1)'(1);
    assign w_cand_ok = (w_cand < (W+1)'(r_sp_max)) && (w_cand > (W+1)'(r_sp_min));

    always_comb begin
        n_setpoint = r_setpoint;
        n_mode     = r_mode;
        n_meas     = r_meas;
        n_have     = r_have;
        n_hold     = r_hold;
        n_fault    = r_fault;
        if (!r_fault) begin
            if (i_func == thc_pkg::FUNC_SAMPLE) begin
                if (!i_sample_valid) begin
                    n_fault = 1'b1;
                    n_mode  = thc_pkg::MODE_STOP;
                end else begin
                    n_meas = i_sample_value;
                    n_have = 1'b1;
                    if (w_samp_x > w_sp_x + w_marg_x) begin
                        n_mode = thc_pkg::MODE_COOL;
                    end else if (w_samp_x < w_sp_x - w_marg_x) begin
                        n_mode = thc_pkg::MODE_HEAT;
                    end else if ((r_mode == thc_pkg::MODE_HEAT && w_samp_x >= w_sp_x) ||
                                 (r_mode == thc_pkg::MODE_COOL && w_samp_x <= w_sp_x)) begin
                        n_mode = thc_pkg::MODE_STOP;
                    end
                end
            end else if (i_func == thc_pkg::FUNC_TICK) begin
                if (r_hold != 8'd0) begin
                    n_hold = r_hold - 8'd1;
                end
            end else if (r_have) begin
                if (r_hold != 8'd0 && !i_button_level && w_cand_ok) begin
                    n_setpoint = w_cand[W-1:0];
                    priority if (r_meas > $signed(w_cand[W-1:0])) begin
                        n_mode = thc_pkg::MODE_COOL;
                    end else if (r_meas < $signed(w_cand[W-1:0])) begin
                        n_mode = thc_pkg::MODE_HEAT;
                    end else begin
                        n_mode = thc_pkg::MODE_STOP;
                    end
                end
                n_hold = (r_hold_cfg != 8'd0) ? r_hold_cfg : 8'd1;
            end
        end
    end

    always_comb begin
        priority if (n_fault) begin
            w_disp = '0;
            w_kind = thc_pkg::KIND_FAULT;
        end else if (n_hold != 8'd0) begin
            w_disp = n_setpoint;
            w_kind = thc_pkg::KIND_SETPOINT;
        end else begin
            w_disp = n_meas;
            w_kind = thc_pkg::KIND_MEASURED;
        end
    end

    assign w_res = {!n_fault && n_mode == thc_pkg::MODE_HEAT,
                    !n_fault && n_mode == thc_pkg::MODE_COOL,
                    w_disp, w_kind, n_fault};

    // configuration and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin   <= thc_pkg::MARGIN_RST;
            r_sp_max   <= W'(thc_pkg::SP_MAX_RST);
            r_sp_min   <= W'(thc_pkg::SP_MIN_RST);
            r_hold_cfg <= thc_pkg::HOLD_RST;
            r_sp_start <= W'(thc_pkg::SP_START_RST);
            r_setpoint <= W'(thc_pkg::SP_START_RST);
            r_mode     <= thc_pkg::MODE_STOP;
            r_meas     <= '0;
            r_have     <= 1'b0;
            r_hold     <= 8'd0;
            r_fault    <= 1'b0;
        end else if (w_wr) begin
            unique case (w_idx)
                thc_pkg::REG_MARGIN: r_margin   <= pwdata[3:0];
                thc_pkg::REG_SP_MAX: r_sp_max   <= pwdata[W-1:0];
                thc_pkg::REG_SP_MIN: r_sp_min   <= pwdata[W-1:0];
                thc_pkg::REG_HOLD:   r_hold_cfg <= pwdata[7:0];
                thc_pkg::REG_SP_START: begin
                    r_sp_start <= pwdata[W-1:0];
                    r_setpoint <= pwdata[W-1:0];
                end
                default: ;
            endcase
        end else if (w_acc) begin
            r_setpoint <= n_setpoint;
            r_mode     <= n_mode;
            r_meas     <= n_meas;
            r_have     <= n_have;
            r_hold     <= n_hold;
            r_fault    <= n_fault;
        end
    end

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || w_take) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= w_acc;
            end else begin
                r_ov <= w_acc;
            end
        end else if (w_acc) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || w_take) begin
            if (r_sv) begin
                r_out <= r_skd;
                if (w_acc) begin
                    r_skd <= w_res;
                end
            end else if (w_acc) begin
                r_out <= w_res;
            end
        end else if (w_acc) begin
            r_skd <= w_res;
        end
    end

    assign o_valid         = r_ov;
    assign o_heat_on       = r_out[RW-1];
    assign o_cool_on       = r_out[RW-2];
    assign o_display_value = r_out[RW-3:3];
    assign o_display_kind  = r_out[2:1];
    assign o_fault         = r_out[0];

endmodule
